### rtl/core/ikc_pkg.sv
// Shared types, constants and codes of the image kernel convolution block.
package ikc_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int LIMIT_ROWS = 4096;
  localparam int RING_ROWS  = 2 * MAX_KERNEL;
  localparam int EDGE_VALUE = 255;

  localparam int TAP_DEPTH  = MAX_KERNEL * MAX_KERNEL;
  localparam int LINE_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int TAP_AW     = $clog2(TAP_DEPTH);
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(LIMIT_ROWS) + 1;
  localparam int RING_W     = $clog2(RING_ROWS);
  localparam int LIN_W      = $clog2(MAX_WIDTH * LIMIT_ROWS) + 1;

  localparam int CQ_DEPTH   = 4;
  localparam int CQ_AW      = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH   = 2;
  localparam int RQ_AW      = $clog2(RQ_DEPTH);

  typedef enum logic [1:0] {
    ACT_TAP   = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_DRAIN = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_KERNEL  = 2'd0,
    CFG_DIVISOR = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_HEIGHT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_TAP   = 2'd1,
    CMD_PIXEL = 2'd2,
    CMD_DRAIN = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_ISSUE,
    BK_FLUSH,
    BK_DIVPRE,
    BK_DIV,
    BK_PUSH
  } bk_state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         pix_blue;
    logic [7:0]         pix_green;
    logic [7:0]         pix_red;
    logic [2:0]         tap_row;
    logic [2:0]         tap_col;
    logic signed [15:0] tap_weight;
  } in_t;

  typedef struct packed {
    logic [7:0] res_blue;
    logic [7:0] res_green;
    logic [7:0] res_red;
    logic       frame_done;
  } res_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [TAP_AW-1:0]  tap_idx;
    logic signed [15:0] weight;
    logic [23:0]        pixel;
  } cmd_t;

endpackage

### rtl/core/ikc_front.sv
// Front end: decodes input requests and queues them for the engine.
module ikc_front (
  input  logic         clk,
  input  logic         rst_n,
  input  ikc_pkg::in_t in_data,
  input  logic         in_push,
  output logic         in_full,
  output ikc_pkg::cmd_t q_head,
  output logic         q_empty,
  input  logic         q_pop
);
  import ikc_pkg::*;

  cmd_t              q_mem [CQ_DEPTH];
  cmd_t              cmd;
  logic [CQ_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CQ_AW:0]    count_r;
  logic              push_ok, pop_ok;

  // Decode the action; a tap outside the kernel grid turns into a no-op.
  always_comb begin
    cmd         = '0;
    cmd.kind    = CMD_NOP;
    cmd.tap_idx = TAP_AW'(in_data.tap_row) * TAP_AW'(MAX_KERNEL) + TAP_AW'(in_data.tap_col);
    cmd.weight  = in_data.tap_weight;
    cmd.pixel   = {in_data.pix_red, in_data.pix_green, in_data.pix_blue};
    case (in_data.action)
      ACT_TAP: begin
        if (in_data.tap_row < 3'(MAX_KERNEL) && in_data.tap_col < 3'(MAX_KERNEL)) begin
          cmd.kind = CMD_TAP;
        end
      end
      ACT_PIXEL: cmd.kind = CMD_PIXEL;
      ACT_DRAIN: cmd.kind = CMD_DRAIN;
      default:   cmd.kind = CMD_NOP;
    endcase
  end

  assign in_full = (count_r == (CQ_AW+1)'(CQ_DEPTH));
  assign q_empty = (count_r == '0);
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && !q_empty;
  assign q_head  = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (CQ_AW+1)'(push_ok) - (CQ_AW+1)'(pop_ok);
    end
  end

endmodule

### rtl/core/ikc_res_fifo.sv
// Result queue between the engine and the output port.
module ikc_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ikc_pkg::res_t push_data,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output ikc_pkg::res_t head
);
  import ikc_pkg::*;

  res_t             mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_AW:0]   count_r;
  logic             push_ok, pop_ok;

  assign full    = (count_r == (RQ_AW+1)'(RQ_DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (RQ_AW+1)'(push_ok) - (RQ_AW+1)'(pop_ok);
    end
  end

endmodule

### rtl/core/ikc_back.sv
// Engine: tap and line memories, frame counters, tap-serial MAC and divider.
module ikc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  ikc_pkg::cmd_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          res_push,
  output ikc_pkg::res_t res_data,
  input  logic          res_full
);
  import ikc_pkg::*;

  // configuration and derived values
  logic [2:0]  ksz_r;
  logic [15:0] div_r;
  logic [10:0] fw_r;
  logic [12:0] fh_r;
  logic [2:0]  k_r;
  logic [1:0]  half_r, tail_r;
  logic [10:0] w_r;
  logic [12:0] h_r;
  logic [15:0] dv_r;
  logic [LIN_W-1:0] total_r;
  logic [LIN_W-1:0] lag_r;

  // frame position
  logic [ROW_W-1:0]  in_row_r, out_row_r;
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic [RING_W-1:0] in_ring_r, out_ring_r;
  logic [LIN_W-1:0]  in_lin_r, out_lin_r;

  // compute loop
  bk_state_t state_r, state_nxt;
  logic [2:0]  ti_r, tj_r, bit_r;
  logic [RING_W-1:0] ring_r;
  logic        v1_r, edge1_r, v2_r;
  logic signed [15:0] tap_rd_r;
  logic [23:0] pix_rd_r;
  logic signed [24:0] prod_r [3];
  logic signed [31:0] acc_r  [3];
  logic [30:0] rem_r [3];
  logic [7:0]  q_r   [3];
  logic [2:0]  pos_r, sat_r;

  logic signed [15:0] tap_mem  [TAP_DEPTH];
  logic [23:0]        line_mem [LINE_DEPTH];

  logic tap_we, line_we;
  logic [TAP_AW-1:0]  tap_raddr;
  logic [LINE_AW-1:0] line_waddr, line_raddr;
  logic signed [14:0] rr;
  logic signed [11:0] cc;
  logic outside, issue_last, in_done, go, frame_end;
  logic [LIN_W-1:0] received;
  logic [4:0] ring_start;

  // Effective register values, recomputed each cycle.
  always_ff @(posedge clk) begin
    k_r     <= (ksz_r == 3'd0) ? 3'd1 : ksz_r;
    half_r  <= 2'(((ksz_r == 3'd0) ? 3'd1 : ksz_r) >> 1);
    tail_r  <= 2'(((ksz_r == 3'd0) ? 3'd1 : ksz_r) - 3'd1 -
                  (((ksz_r == 3'd0) ? 3'd1 : ksz_r) >> 1));
    w_r     <= (fw_r == '0) ? 11'd1 : (fw_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : fw_r;
    h_r     <= (fh_r == '0) ? 13'd1 : (fh_r > 13'(LIMIT_ROWS)) ? 13'(LIMIT_ROWS) : fh_r;
    dv_r    <= (div_r == '0) ? 16'd1 : div_r;
    total_r <= LIN_W'(w_r) * LIN_W'(h_r);
    lag_r   <= LIN_W'(tail_r) * LIN_W'(w_r) + LIN_W'(tail_r);
  end

  // Window tap position for the current issue step.
  assign rr = $signed({2'b00, out_row_r}) - $signed({13'd0, half_r}) + $signed({12'd0, ti_r});
  assign cc = $signed({2'b00, out_col_r}) - $signed({10'd0, half_r}) + $signed({9'd0, tj_r});
  assign outside = (rr < 0) || (rr >= $signed({2'b00, h_r})) ||
                   (cc < 0) || (cc >= $signed({1'b0, w_r}));
  assign issue_last = (ti_r == k_r - 3'd1) && (tj_r == k_r - 3'd1);

  assign tap_raddr  = TAP_AW'(ti_r) * TAP_AW'(MAX_KERNEL) + TAP_AW'(tj_r);
  assign line_raddr = LINE_AW'(ring_r) * LINE_AW'(MAX_WIDTH) + LINE_AW'(cc[COL_W-1:0]);
  assign line_waddr = LINE_AW'(in_ring_r) * LINE_AW'(MAX_WIDTH) + LINE_AW'(in_col_r);

  assign in_done   = (in_row_r >= h_r);
  assign received  = in_done ? total_r : in_lin_r;
  assign go        = (out_lin_r < total_r) && (in_done || (out_lin_r + lag_r < received));
  assign frame_end = (out_lin_r + 1'b1 >= total_r);
  assign ring_start = (out_ring_r >= RING_W'(half_r)) ? 5'(out_ring_r) - 5'(half_r)
                    : 5'(out_ring_r) + 5'(RING_ROWS) - 5'(half_r);

  // Memories.
  always_ff @(posedge clk) begin
    if (tap_we) tap_mem[q_head.tap_idx] <= q_head.weight;
    tap_rd_r <= tap_mem[tap_raddr];
  end

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_waddr] <= q_head.pixel;
    pix_rd_r <= line_mem[line_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    tap_we    = 1'b0;
    line_we   = 1'b0;
    res_push  = 1'b0;
    res_data.res_blue   = pos_r[0] ? (sat_r[0] ? 8'(EDGE_VALUE) : q_r[0]) : 8'd0;
    res_data.res_green  = pos_r[1] ? (sat_r[1] ? 8'(EDGE_VALUE) : q_r[1]) : 8'd0;
    res_data.res_red    = pos_r[2] ? (sat_r[2] ? 8'(EDGE_VALUE) : q_r[2]) : 8'd0;
    res_data.frame_done = frame_end;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.kind)
            CMD_TAP: tap_we = 1'b1;
            CMD_PIXEL: begin
              line_we   = (in_row_r < h_r);
              state_nxt = BK_CHECK;
            end
            CMD_DRAIN: state_nxt = BK_CHECK;
            default: ;
          endcase
        end
      end
      BK_CHECK:  state_nxt = go ? BK_ISSUE : BK_IDLE;
      BK_ISSUE:  if (issue_last) state_nxt = BK_FLUSH;
      BK_FLUSH:  if (!v1_r && !v2_r) state_nxt = BK_DIVPRE;
      BK_DIVPRE: state_nxt = BK_DIV;
      BK_DIV:    if (bit_r == 3'd0) state_nxt = BK_PUSH;
      BK_PUSH: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Configuration and frame counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksz_r      <= 3'd3;
      div_r      <= 16'd1;
      fw_r       <= 11'(MAX_WIDTH);
      fh_r       <= 13'd1024;
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      in_lin_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
      out_lin_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL:  ksz_r <= cfg_data[2:0];
        CFG_DIVISOR: div_r <= cfg_data;
        CFG_WIDTH:   fw_r  <= cfg_data[10:0];
        CFG_HEIGHT:  fh_r  <= cfg_data[12:0];
        default: ;
      endcase
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      in_lin_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
      out_lin_r  <= '0;
    end else begin
      if (line_we) begin
        in_lin_r <= in_lin_r + 1'b1;
        if ({1'b0, in_col_r} + 11'd1 >= w_r) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + 1'b1;
          in_ring_r <= (in_ring_r == RING_W'(RING_ROWS-1)) ? '0 : in_ring_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end
      if (res_push) begin
        if (frame_end) begin
          in_row_r   <= '0;
          in_col_r   <= '0;
          in_ring_r  <= '0;
          in_lin_r   <= '0;
          out_row_r  <= '0;
          out_col_r  <= '0;
          out_ring_r <= '0;
          out_lin_r  <= '0;
        end else begin
          out_lin_r <= out_lin_r + 1'b1;
          if ({1'b0, out_col_r} + 11'd1 >= w_r) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + 1'b1;
            out_ring_r <= (out_ring_r == RING_W'(RING_ROWS-1)) ? '0 : out_ring_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

  // Tap loop, accumulate and divide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= (state_r == BK_ISSUE);
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    edge1_r <= outside;
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= tap_rd_r * $signed({1'b0, (edge1_r ? 8'(EDGE_VALUE) : pix_rd_r[c*8 +: 8])});
      if (v2_r) acc_r[c] <= acc_r[c] + 32'(prod_r[c]);
    end
    case (state_r)
      BK_CHECK: begin
        ti_r   <= '0;
        tj_r   <= '0;
        ring_r <= RING_W'(ring_start);
        for (int c = 0; c < 3; c++) acc_r[c] <= '0;
      end
      BK_ISSUE: begin
        if (tj_r == k_r - 3'd1) begin
          tj_r   <= '0;
          ti_r   <= ti_r + 1'b1;
          ring_r <= (ring_r == RING_W'(RING_ROWS-1)) ? '0 : ring_r + 1'b1;
        end else begin
          tj_r <= tj_r + 1'b1;
        end
      end
      BK_DIVPRE: begin
        bit_r <= 3'd7;
        for (int c = 0; c < 3; c++) begin
          pos_r[c] <= (acc_r[c] > 0);
          sat_r[c] <= (acc_r[c][30:0] >= {7'd0, dv_r, 8'd0});
          rem_r[c] <= acc_r[c][30:0];
          q_r[c]   <= '0;
        end
      end
      BK_DIV: begin
        bit_r <= bit_r - 1'b1;
        for (int c = 0; c < 3; c++) begin
          if (rem_r[c] >= (31'(dv_r) << bit_r)) begin
            rem_r[c]       <= rem_r[c] - (31'(dv_r) << bit_r);
            q_r[c][bit_r]  <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/image_kernel_convolution.sv
// Top level of the streaming 2-D image convolution block.
// Streaming BGR convolution with a square signed kernel of side 1..7. Requests
// enter a four-deep command queue (push/full); results leave a two-deep result
// queue (pop/empty), so either side may stall without losing anything. A
// coefficient load or a no-op request is handled in the idle state alone. A pixel or
// drain request that produces a result passes through these steps, plus any wait
// for room in the result queue: take the request, check the window, walk the
// kernel one tap per cycle (one read port on each of the tap and line memories,
// one multiply-accumulate per channel), drain the multiply pipeline, then one
// setup step and eight steps of a restoring divider per channel, the three
// running side by side, and push the result. A request that produces no result
// returns to idle after the window check. Results trail the input by (k-1)/2
// rows and columns, rounded down; after the last pixel, one drain request
// flushes each remaining result, and frame_done marks the last one. Taps that
// fall outside the image read 255. Each sum is divided by the divisor (zero
// acts as one), truncated toward zero and clamped to 0..255. Write every
// coefficient before a frame starts: the tap and line memories are not
// cleared after reset. Any register write restarts the frame counters; write
// registers only while no request is in flight.
module image_kernel_convolution (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  ikc_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output ikc_pkg::res_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import ikc_pkg::*;

  cmd_t q_head;
  logic q_empty, q_pop;
  logic res_push, res_full;
  res_t res_data;

  // Front: decode and queue requests.
  ikc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .in_push (in_push),
    .in_full (in_full),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop)
  );

  // Back: hold configuration, store lines, run the window MAC and divide.
  ikc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  // Result queue: hold finished pixels until the consumer pops them.
  ikc_res_fifo u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .empty     (out_empty),
    .pop       (out_pop),
    .head      (out_data)
  );

endmodule

### test/tb_top.sv
// Testbench for image_kernel_convolution: streams frames and checks every result.
`timescale 1ns / 100ps

module tb_top;
  import ikc_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE       = 100;   // worst request latency plus the command queue

  logic  clk;
  logic  rst_n;
  logic  in_push;
  logic  in_full;
  in_t   in_data;
  logic  out_empty;
  logic  out_pop;
  res_t  out_data;
  logic  cfg_we;
  logic  [1:0] cfg_index;
  logic  [15:0] cfg_data;

  image_kernel_convolution dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  in_t  pending_requests[$];
  res_t expected_pixels[$];
  int   send_idle_pct;
  int   pop_stall_pct;
  int   mismatches = 0;
  int   results_seen = 0;
  int   stream_items;
  int   cycles = 0;

  // Mirror of the block: registers, coefficients, line ring and frame counters.
  logic [2:0]         kernel_reg;
  logic [15:0]        divisor_reg;
  logic [10:0]        width_reg;
  logic [12:0]        height_reg;
  logic signed [15:0] coeffs[TAP_DEPTH];
  logic [23:0]        line_ring[LINE_DEPTH];
  int                 in_row, in_col, out_row, out_col;

  function automatic logic [7:0] scale_clamp(longint sum, longint div);
    longint q;
    q = sum / div;   // truncates toward zero
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // Advance the mirror by one accepted request; queue the pixel it releases, if any.
  task automatic convolve_request(in_t req);
    int k, half, tail, w, h, total, lag, received, olin, rr, cc;
    longint sb, sg, sr, wt, div;
    logic [23:0] px;
    res_t r;
    if (req.action == ACT_TAP) begin
      if (req.tap_row < MAX_KERNEL && req.tap_col < MAX_KERNEL)
        coeffs[req.tap_row * MAX_KERNEL + req.tap_col] = req.tap_weight;
      return;
    end
    if (req.action == ACT_NONE) return;
    k = (kernel_reg == 0) ? 1 : kernel_reg;
    half = k / 2;
    tail = k - 1 - half;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > LIMIT_ROWS) ? LIMIT_ROWS : height_reg);
    total = w * h;
    lag = tail * w + tail;
    if (req.action == ACT_PIXEL && in_row < h) begin
      line_ring[(in_row % RING_ROWS) * MAX_WIDTH + in_col] =
        {req.pix_red, req.pix_green, req.pix_blue};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    received = (in_row >= h) ? total : in_row * w + in_col;
    olin = out_row * w + out_col;
    if (olin >= total) return;
    if (in_row < h && !(olin + lag < received)) return;
    sb = 0; sg = 0; sr = 0;
    for (int i = 0; i < k; i++) begin
      rr = out_row - half + i;
      for (int j = 0; j < k; j++) begin
        cc = out_col - half + j;
        wt = coeffs[i * MAX_KERNEL + j];
        if (rr < 0 || rr >= h || cc < 0 || cc >= w) px = {3{8'd255}};
        else px = line_ring[(rr % RING_ROWS) * MAX_WIDTH + cc];
        sb += wt * longint'(px[7:0]);
        sg += wt * longint'(px[15:8]);
        sr += wt * longint'(px[23:16]);
      end
    end
    div = (divisor_reg == 0) ? 1 : divisor_reg;
    r.res_blue = scale_clamp(sb, div);
    r.res_green = scale_clamp(sg, div);
    r.res_red = scale_clamp(sr, div);
    r.frame_done = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (olin + 1 >= total) begin
      r.frame_done = 1'b1;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end
    expected_pixels.push_back(r);
  endtask

  // Driver: hold a refused request, otherwise issue the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_push && !in_full) convolve_request(in_data);
      if (!in_push || !in_full) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_push <= 1'b1;
          in_data <= pending_requests.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped pixel against the oldest prediction; stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          res_t exp_px;
          exp_px = expected_pixels.pop_front();
          if (out_data.res_blue !== exp_px.res_blue || out_data.res_green !== exp_px.res_green
              || out_data.res_red !== exp_px.res_red
              || out_data.frame_done !== exp_px.frame_done) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_px, out_data);
          end
        end
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_t rand_request(action_t act);
    in_t req;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    req = noise[$bits(in_t)-1:0];
    req.action = act;
    case ($urandom_range(7))
      0: {req.pix_blue, req.pix_green, req.pix_red} = '0;
      1: {req.pix_blue, req.pix_green, req.pix_red} = '1;
      default: ;
    endcase
    return req;
  endfunction

  // Wait until every request is taken and every prediction popped, then let stragglers finish.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_push || expected_pixels.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Reprogram all four registers; each write restarts the frame counters.
  task automatic program_regs(int k, int div, int w, int h);
    int vals[4];
    vals = '{k, div, w, h};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= 16'(vals[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    kernel_reg  = 3'(k);
    divisor_reg = 16'(div);
    width_reg   = 11'(w);
    height_reg  = 13'(h);
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endtask

  // One frame: load all taps, stream pixels with noise, then flush if the frame completes.
  task automatic run_frame(int k, int div, int w, int h, int npix, bit wide_taps,
                           int idle_pct, int stall_pct);
    in_t req;
    int ke, we, he, tail, flush;
    wait_idle();
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    program_regs(k, div, w, h);
    for (int t = 0; t < TAP_DEPTH; t++) begin
      req = rand_request(ACT_TAP);
      req.tap_row = 3'(t / MAX_KERNEL);
      req.tap_col = 3'(t % MAX_KERNEL);
      if (!wide_taps) req.tap_weight = 16'(int'($urandom_range(40)) - 8);
      else if (t == 0) req.tap_weight = 16'sh8000;
      else if (t == 1) req.tap_weight = 16'sh7fff;
      pending_requests.push_back(req);
      stream_items++;
    end
    for (int p = 0; p < npix; p++) begin
      // sprinkle harmless noise: no-ops, early drains, out-of-range tap loads
      case ($urandom_range(19))
        0: begin
          pending_requests.push_back(rand_request(ACT_NONE));
          stream_items++;
        end
        1: begin
          pending_requests.push_back(rand_request(ACT_DRAIN));
          stream_items++;
        end
        2: begin
          req = rand_request(ACT_TAP);
          if ($urandom_range(1)) req.tap_row = 3'(MAX_KERNEL);
          else req.tap_col = 3'd7;
          pending_requests.push_back(req);
          stream_items++;
        end
        default: ;
      endcase
      pending_requests.push_back(rand_request(ACT_PIXEL));
      stream_items++;
    end
    ke = (k == 0) ? 1 : k;
    we = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    he = (h == 0) ? 1 : ((h > LIMIT_ROWS) ? LIMIT_ROWS : h);
    if (npix == we * he) begin
      tail = ke - 1 - ke / 2;
      flush = tail * we + tail;
      // surplus pixels before frame end act as drains
      for (int d = 0; d < flush; d++)
        pending_requests.push_back(rand_request($urandom_range(4) == 0 ? ACT_PIXEL : ACT_DRAIN));
      pending_requests.push_back(rand_request(ACT_DRAIN));   // past frame end: no result
      stream_items += flush + 1;
    end
  endtask

  initial begin
    int phase, k, w, h, div, modes[4][2];
    modes = '{'{0, 0}, '{51, 0}, '{0, 51}, '{30, 30}};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_KERNEL;
    cfg_data = '0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    stream_items = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames: extreme taps, sizes and register values
    run_frame(3, 1, 4, 3, 12, 1'b1, 0, 0);
    run_frame(7, 0, 5, 4, 20, 1'b0, 0, 0);
    run_frame(1, 65535, 3, 2, 6, 1'b1, 51, 0);
    run_frame(2, 7, 2047, 1, 300, 1'b0, 0, 51);      // width saturates; even kernel; cut short
    run_frame(1, 3, 1, 4096, 24, 1'b0, 30, 30);       // tall frame, cut short by rewrite
    run_frame(0, 1, 0, 0, 1, 1'b0, 0, 0);             // zero size fields act as one
    run_frame(5, 50, 6, 8191, 20, 1'b0, 51, 51);
    run_frame(7, 40, 1, 1, 1, 1'b0, 0, 0);

    phase = 0;
    while (stream_items < 1750) begin
      k = $urandom_range(7);
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 7);
      case ($urandom_range(5))
        0: div = 0;
        1: div = 65535;
        2: div = 1;
        default: div = $urandom_range(2, 300);
      endcase
      run_frame(k, div, w, h, ($urandom_range(5) == 0) ? $urandom_range(1, w * h) : w * h,
                $urandom_range(3) == 0, modes[phase % 4][0], modes[phase % 4][1]);
      phase++;
    end

    wait_idle();
    $display("streamed %0d requests over eight directed and %0d random frames",
             stream_items, phase);
    $display("checked %0d filtered pixels, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
